// ===== hdl/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

  localparam int DEF_FRAC_BITS = 8;
  localparam int DEF_WORD_BITS = 32;
  localparam int FIELD_BITS    = 32;
  localparam int OP_BITS       = 4;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

endpackage
`default_nettype wire

// ===== hdl/fpa_if.sv =====
`default_nettype none
interface fpa_in_if import fpa_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [OP_BITS-1:0]           operation;
  logic signed [FIELD_BITS-1:0] operand_a;
  logic signed [FIELD_BITS-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_out_if import fpa_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] result;
  logic                         a_less;
  logic                         a_equal;
  logic                         a_greater;
  logic                         saturated;
  logic                         divide_by_zero;

  modport source (output valid, output result, output a_less, output a_equal,
                  output a_greater, output saturated, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input result, input a_less, input a_equal,
                  input a_greater, input saturated, input divide_by_zero,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/fpa_div.sv =====
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
// Dividend is num_mag shifted left by FRAC_BITS+1, so the quotient carries
// one extra fraction bit for rounding.
module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [WORD_BITS-1:0]               num_mag,
  input  wire logic [WORD_BITS-1:0]               den_mag,
  output logic      [WORD_BITS+FRAC_BITS:0]       quo
);
  localparam int W  = WORD_BITS;
  localparam int NQ = WORD_BITS + FRAC_BITS + 1;

  logic [W-1:0]  rem_r [NQ];
  logic [NQ-1:0] dvd_r [NQ];
  logic [NQ-1:0] quo_r [NQ];
  logic [W-1:0]  den_r [NQ];

  logic [W-1:0]  rem_in [NQ];
  logic [NQ-1:0] dvd_in [NQ];
  logic [NQ-1:0] quo_in [NQ];
  logic [W-1:0]  den_in [NQ];

  logic [W:0]    trial   [NQ];
  logic [W-1:0]  rem_nxt [NQ];
  logic          bit_nxt [NQ];

  genvar i;
  generate
    for (i = 0; i < NQ; i++) begin : g_stage
      if (i == 0) begin : g_first
        assign rem_in[i] = '0;
        assign dvd_in[i] = {num_mag, {(FRAC_BITS+1){1'b0}}};
        assign quo_in[i] = '0;
        assign den_in[i] = den_mag;
      end else begin : g_next
        assign rem_in[i] = rem_r[i-1];
        assign dvd_in[i] = dvd_r[i-1];
        assign quo_in[i] = quo_r[i-1];
        assign den_in[i] = den_r[i-1];
      end

      always_comb begin
        trial[i]   = {rem_in[i], dvd_in[i][NQ-1]};
        bit_nxt[i] = (trial[i] >= {1'b0, den_in[i]});
        if (bit_nxt[i]) begin
          rem_nxt[i] = W'(trial[i] - {1'b0, den_in[i]});
        end else begin
          rem_nxt[i] = trial[i][W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt[i];
          dvd_r[i] <= {dvd_in[i][NQ-2:0], 1'b0};
          quo_r[i] <= {quo_in[i][NQ-2:0], bit_nxt[i]};
          den_r[i] <= den_in[i];
        end
      end
    end
  endgenerate

  assign quo = quo_r[NQ-1];

endmodule
`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
`default_nettype none
// Signed fixed-point ALU, WORD_BITS-bit raw values with FRAC_BITS fraction bits.
// One transaction per cycle is accepted while the output is not stalled. The
// pipeline depth is set by the divider, which resolves one quotient bit per stage.
// All operations flow through the same pipeline so results leave in order. A stall
// at the output holds every stage.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NQ = W + F + 1;
  localparam int WX = W + F + 1;
  localparam int PW = 2 * W + 1;
  localparam int MQ = PW - F;

  localparam logic signed [W-1:0]  RMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  RMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [WX-1:0] XMAX = {{(WX-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [WX-1:0] XMIN = {{(WX-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);
  localparam logic [MQ-1:0] MLIM_NG = MQ'(1) << (W - 1);
  localparam logic [MQ-1:0] MLIM_PS = MLIM_NG - MQ'(1);
  localparam logic [NQ-1:0] DLIM_NG = NQ'(1) << (W - 1);
  localparam logic [NQ-1:0] DLIM_PS = DLIM_NG - NQ'(1);

  typedef struct packed {
    logic                 valid;
    logic                 is_mul;
    logic                 is_div;
    logic                 neg;
    logic                 a_zero;
    logic                 a_neg;
    logic                 dz;
    logic                 lt;
    logic                 eq;
    logic                 gt;
    logic signed [WX-1:0] wide;
    logic [2*W-1:0]       prod;
  } calc_t;

  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic                neg;
    logic                a_zero;
    logic                a_neg;
    logic                dz;
    logic                lt;
    logic                eq;
    logic                gt;
    logic signed [W-1:0] res;
    logic                sat;
  } side_t;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // input register
  logic                in_valid_r;
  logic [OP_BITS-1:0]  op_r;
  logic signed [W-1:0] a_r;
  logic signed [W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= in_ch.operation;
      a_r  <= in_ch.operand_a[W-1:0];
      b_r  <= in_ch.operand_b[W-1:0];
    end
  end

  logic [W-1:0] amag;
  logic [W-1:0] bmag;
  assign amag = a_r[W-1] ? (~a_r + 1'b1) : a_r;
  assign bmag = b_r[W-1] ? (~b_r + 1'b1) : b_r;

  logic [NQ-1:0] quo;
  fpa_div #(.FRAC_BITS(F), .WORD_BITS(W)) u_div (
    .clk     (clk),
    .en      (en),
    .num_mag (amag),
    .den_mag (bmag),
    .quo     (quo)
  );

  // stage X: raw arithmetic, multiplier
  calc_t                x_nxt, x_r;
  logic signed [WX-1:0] ax, bx;
  assign ax = WX'(a_r);
  assign bx = WX'(b_r);

  always_comb begin
    x_nxt        = '0;
    x_nxt.valid  = in_valid_r;
    x_nxt.lt     = (a_r < b_r);
    x_nxt.eq     = (a_r == b_r);
    x_nxt.gt     = (a_r > b_r);
    x_nxt.neg    = a_r[W-1] ^ b_r[W-1];
    x_nxt.a_zero = (a_r == '0);
    x_nxt.a_neg  = a_r[W-1];
    x_nxt.dz     = 1'b0;
    x_nxt.prod   = (2*W)'(amag) * (2*W)'(bmag);
    case (op_r)
      OP_ADD:      x_nxt.wide = ax + bx;
      OP_SUB:      x_nxt.wide = ax - bx;
      OP_MUL:      x_nxt.is_mul = 1'b1;
      OP_DIV: begin
        x_nxt.is_div = 1'b1;
        x_nxt.dz     = (b_r == '0);
      end
      OP_MIN:      x_nxt.wide = (a_r < b_r) ? ax : bx;
      OP_MAX:      x_nxt.wide = (a_r > b_r) ? ax : bx;
      OP_INC:      x_nxt.wide = ax + WX'(1);
      OP_DEC:      x_nxt.wide = ax - WX'(1);
      OP_TO_INT:   x_nxt.wide = WX'(a_r >>> F);
      OP_FROM_INT: x_nxt.wide = ax <<< F;
      default:     x_nxt.wide = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r.valid <= 1'b0;
    end else if (en) begin
      x_r <= x_nxt;
    end
  end

  // stage Y: round and clamp everything but divide
  side_t         y_nxt;
  logic [PW-1:0] mr;
  logic [MQ-1:0] mq;
  assign mr = PW'(x_r.prod) + HALF;
  assign mq = mr[PW-1:F];

  always_comb begin
    y_nxt.valid  = x_r.valid;
    y_nxt.is_div = x_r.is_div;
    y_nxt.neg    = x_r.neg;
    y_nxt.a_zero = x_r.a_zero;
    y_nxt.a_neg  = x_r.a_neg;
    y_nxt.dz     = x_r.dz;
    y_nxt.lt     = x_r.lt;
    y_nxt.eq     = x_r.eq;
    y_nxt.gt     = x_r.gt;
    y_nxt.sat    = 1'b0;
    if (x_r.is_mul) begin
      if (x_r.neg) begin
        if (mq > MLIM_NG) begin
          y_nxt.res = RMIN;
          y_nxt.sat = 1'b1;
        end else begin
          y_nxt.res = W'(~mq + 1'b1);
        end
      end else if (mq > MLIM_PS) begin
        y_nxt.res = RMAX;
        y_nxt.sat = 1'b1;
      end else begin
        y_nxt.res = mq[W-1:0];
      end
    end else if (x_r.wide > XMAX) begin
      y_nxt.res = RMAX;
      y_nxt.sat = 1'b1;
    end else if (x_r.wide < XMIN) begin
      y_nxt.res = RMIN;
      y_nxt.sat = 1'b1;
    end else begin
      y_nxt.res = x_r.wide[W-1:0];
    end
  end

  // side line, aligned with the divider stages
  side_t side_r [NQ-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NQ - 1; k++) begin
        side_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= y_nxt;
      for (int k = 1; k < NQ - 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // final: round the quotient, merge
  side_t         fin;
  logic [NQ:0]   qr;
  logic [NQ-1:0] dq;
  logic signed [W-1:0] res_nxt;
  logic                sat_nxt;

  assign fin = side_r[NQ-2];
  assign qr  = (NQ+1)'(quo) + (NQ+1)'(1);
  assign dq  = qr[NQ:1];

  always_comb begin
    res_nxt = fin.res;
    sat_nxt = fin.sat;
    if (fin.is_div) begin
      sat_nxt = 1'b0;
      if (fin.dz) begin
        if (fin.a_zero) begin
          res_nxt = '0;
        end else if (fin.a_neg) begin
          res_nxt = RMIN;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = RMAX;
          sat_nxt = 1'b1;
        end
      end else if (fin.neg) begin
        if (dq > DLIM_NG) begin
          res_nxt = RMIN;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = W'(~dq + 1'b1);
        end
      end else if (dq > DLIM_PS) begin
        res_nxt = RMAX;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = dq[W-1:0];
      end
    end
  end

  logic                out_valid_r;
  logic signed [W-1:0] res_r;
  logic                sat_r, dz_r, lt_r, eq_r, gt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      dz_r  <= fin.is_div && fin.dz;
      lt_r  <= fin.lt;
      eq_r  <= fin.eq;
      gt_r  <= fin.gt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result         = FIELD_BITS'(res_r);
  assign out_ch.saturated      = sat_r;
  assign out_ch.divide_by_zero = dz_r;
  assign out_ch.a_less         = lt_r;
  assign out_ch.a_equal        = eq_r;
  assign out_ch.a_greater      = gt_r;

`ifndef SYNTHESIS
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({lt_r, eq_r, gt_r}))
    else $error("comparison flags not exclusive");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> (res_r == RMAX || res_r == RMIN))
    else $error("saturated result not at a range end");

  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dz_r) |-> (sat_r == (res_r != '0)))
    else $error("divide by zero result and flag disagree");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(side_r[NQ-2]))
    else $error("pipeline advanced during stall");
`endif

endmodule
`default_nettype wire
